// ----- design/krc_pkg.sv -----
// Shared widths, defaults and command codes for the kernel row cache.
package krc_pkg;

    localparam int KEY_W  = 10;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;
    localparam int DATA_W = 64;
    localparam int CFG_W  = 5;

    localparam int CACHE_ROWS_DEF  = 16;
    localparam int ROW_LEN_DEF     = 1024;
    localparam int ROWS_IN_USE_RST = 16;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SWAP   = 2'd3
    } cmd_t;

endpackage

// ----- design/krc_if.sv -----
// Request, response and configuration channels of the kernel row cache.
interface krc_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [krc_pkg::KEY_W-1:0]   key;
    logic [krc_pkg::KEY_W-1:0]   key2;
    logic [krc_pkg::POS_W-1:0]   pos;
    logic [krc_pkg::LEN_W-1:0]   length;
    logic [krc_pkg::DATA_W-1:0]  value;

    modport source (output valid, cmd, key, key2, pos, length, value, input ready);
    modport sink   (input valid, cmd, key, key2, pos, length, value, output ready);
endinterface

interface krc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [krc_pkg::LEN_W-1:0]   start_res;
    logic                        found;
    logic [krc_pkg::DATA_W-1:0]  read_value;

    modport source (output valid, hit, start_res, found, read_value, input ready);
    modport sink   (input valid, hit, start_res, found, read_value, output ready);
endinterface

interface krc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [krc_pkg::CFG_W-1:0]   rows_in_use;

    modport source (output valid, rows_in_use, input ready);
    modport sink   (input valid, rows_in_use, output ready);
endinterface

// ----- design/krc_ram.sv -----
// Generic simple dual-port RAM with registered read.
module krc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/kernel_row_cache.sv -----
// Top level of the kernel row cache: row tags, sequencer and element memory.
//
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   cmd, key, key2, pos, length, value
// rsp       out  valid/ready   hit, start_res, found, read_value
// cfg       in   valid/ready   rows_in_use (always ready)
//
// Write and read access the element memory, then return the result.
// A lookup that creates or grows a row zeroes each new element through
// the element memory write port, then leaves the fill; a lookup that must
// evict first scans every row for the one with the smallest key.
// A swap walks all rows; for a row whose columns swap it reads both and writes them back crossed.
// Reset clears all row tags at once; element memory needs no clearing.
// A result waiting in the output register holds the sequencer in its
// last step; a new request is taken once the sequencer is back to idle.
module kernel_row_cache #(
    parameter int CACHE_ROWS = krc_pkg::CACHE_ROWS_DEF,
    parameter int ROW_LEN    = krc_pkg::ROW_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    krc_req_if.sink   req,
    krc_rsp_if.source rsp,
    krc_cfg_if.sink   cfg
);

    localparam int SLOT_W    = (CACHE_ROWS > 1) ? $clog2(CACHE_ROWS) : 1;
    localparam int ROW_AW    = $clog2(ROW_LEN);
    localparam int CNT_W     = $clog2(CACHE_ROWS + 1);
    localparam int MEM_AW    = SLOT_W + ROW_AW;
    localparam int MEM_DEPTH = ((CACHE_ROWS > 1) ? CACHE_ROWS : 2) << ROW_AW;
    localparam int KEY_W     = krc_pkg::KEY_W;
    localparam int LEN_W     = krc_pkg::LEN_W;
    localparam int DATA_W    = krc_pkg::DATA_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_ROWS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZERO,
        S_EVCHK,
        S_EVSCAN,
        S_SWROW,
        S_SWRDH,
        S_SWWLO,
        S_SWWHI,
        S_DONE
    } state_t;

    state_t state_reg;

    // Row tags live in flops: small, and every row is compared at once.
    logic              row_valid_reg [CACHE_ROWS];
    logic [KEY_W-1:0]  row_key_reg   [CACHE_ROWS];
    logic [LEN_W-1:0]  row_len_reg   [CACHE_ROWS];
    logic [CNT_W-1:0]  count_reg;
    logic [krc_pkg::CFG_W-1:0] rows_in_use_reg;

    // Request context held while the sequencer works.
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  lo_reg;
    logic [KEY_W-1:0]  hi_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  zc_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [KEY_W-1:0]  best_key_reg;
    logic              best_ok_reg;
    logic [DATA_W-1:0] tmp_reg;

    logic              res_hit_reg;
    logic [LEN_W-1:0]  res_start_reg;
    logic              res_found_reg;
    logic              res_rd_reg;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [LEN_W-1:0]  out_start_reg;
    logic              out_found_reg;
    logic [DATA_W-1:0] out_value_reg;

    // Tag match and free-slot search.
    logic              m_ok;
    logic [SLOT_W-1:0] m_slot;
    logic              m2_ok;
    logic [SLOT_W-1:0] m2_slot;
    logic [SLOT_W-1:0] free_slot;
    logic [CACHE_ROWS-1:0] valid_vec;

    logic [31:0]       len32;
    logic [31:0]       len_max;
    logic [LEN_W-1:0]  len_sat;
    logic [31:0]       limit32;
    logic [LEN_W-1:0]  m_len;
    logic              pos_ok;
    logic              req_fire;

    logic [31:0]       pos32;
    logic [31:0]       lo32;
    logic [31:0]       hi32;
    logic [31:0]       zc32;
    logic [ROW_AW-1:0] col_pos;
    logic [ROW_AW-1:0] col_lo;
    logic [ROW_AW-1:0] col_hi;
    logic [ROW_AW-1:0] col_zc;

    logic              take_cur;
    logic [SLOT_W-1:0] final_slot;
    logic              final_ok;
    logic              cur_valid;
    logic [LEN_W-1:0]  cur_len;

    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [MEM_AW-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.start_res  = out_start_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.read_value = out_value_reg;

    // Lowest matching slot wins, as does the lowest free slot.
    always_comb
    begin
        m_ok      = 1'b0;
        m_slot    = '0;
        m2_ok     = 1'b0;
        m2_slot   = '0;
        free_slot = '0;
        for (int s = CACHE_ROWS - 1; s >= 0; s--)
        begin
            valid_vec[s] = row_valid_reg[s];
            if (row_valid_reg[s] && row_key_reg[s] == req.key)
            begin
                m_ok   = 1'b1;
                m_slot = SLOT_W'(s);
            end
            if (row_valid_reg[s] && row_key_reg[s] == req.key2)
            begin
                m2_ok   = 1'b1;
                m2_slot = SLOT_W'(s);
            end
            if (!row_valid_reg[s])
            begin
                free_slot = SLOT_W'(s);
            end
        end
    end

    // Saturate the requested length and clamp the row limit.
    assign len32   = 32'(req.length);
    assign len_max = 32'(ROW_LEN);
    assign len_sat = (len32 > len_max) ? len_max[LEN_W-1:0] : req.length;
    assign limit32 = (rows_in_use_reg == '0) ? 32'd1 :
                     (32'(rows_in_use_reg) > 32'(CACHE_ROWS)) ? 32'(CACHE_ROWS) :
                     32'(rows_in_use_reg);

    assign m_len  = row_len_reg[m_slot];
    assign pos_ok = m_ok && ({1'b0, req.pos} < m_len);

    assign pos32   = 32'(req.pos);
    assign lo32    = 32'(lo_reg);
    assign hi32    = 32'(hi_reg);
    assign zc32    = 32'(zc_reg);
    assign col_pos = pos32[ROW_AW-1:0];
    assign col_lo  = lo32[ROW_AW-1:0];
    assign col_hi  = hi32[ROW_AW-1:0];
    assign col_zc  = zc32[ROW_AW-1:0];

    assign cur_valid  = row_valid_reg[idx_reg];
    assign cur_len    = row_len_reg[idx_reg];
    assign take_cur   = cur_valid && (!best_ok_reg || row_key_reg[idx_reg] < best_key_reg);
    assign final_slot = take_cur ? idx_reg : best_slot_reg;
    assign final_ok   = take_cur || best_ok_reg;

    // Element memory port steering.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && pos_ok && req.cmd == krc_pkg::CMD_WRITE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {m_slot, col_pos};
                    ram_wdata = req.value;
                end
                if (req_fire && pos_ok && req.cmd == krc_pkg::CMD_READ)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = {m_slot, col_pos};
                end
            end
            S_ZERO:
            begin
                ram_we    = (zc_reg < len_reg);
                ram_waddr = {slot_reg, col_zc};
            end
            S_SWROW:
            begin
                ram_re    = 1'b1;
                ram_raddr = {idx_reg, col_lo};
            end
            S_SWRDH:
            begin
                ram_re    = 1'b1;
                ram_raddr = {idx_reg, col_hi};
            end
            S_SWWLO:
            begin
                ram_we    = 1'b1;
                ram_waddr = {idx_reg, col_lo};
                ram_wdata = ram_rdata;
            end
            S_SWWHI:
            begin
                ram_we    = 1'b1;
                ram_waddr = {idx_reg, col_hi};
                ram_wdata = tmp_reg;
            end
            S_EVCHK, S_EVSCAN, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    krc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            rows_in_use_reg <= krc_pkg::CFG_W'(krc_pkg::ROWS_IN_USE_RST);
            out_valid_reg   <= 1'b0;
            for (int s = 0; s < CACHE_ROWS; s++)
            begin
                row_valid_reg[s] <= 1'b0;
                row_key_reg[s]   <= '0;
                row_len_reg[s]   <= '0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                rows_in_use_reg <= cfg.rows_in_use;
            end
            // Drop the taken result; the last step reloads it itself.
            if (out_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        key_reg       <= req.key;
                        len_reg       <= len_sat;
                        res_hit_reg   <= 1'b0;
                        res_start_reg <= '0;
                        res_found_reg <= 1'b0;
                        res_rd_reg    <= 1'b0;
                        state_reg     <= S_DONE;
                        priority case (req.cmd)
                            krc_pkg::CMD_LOOKUP:
                            begin
                                if (m_ok)
                                begin
                                    res_found_reg <= 1'b1;
                                    if (m_len < len_sat)
                                    begin
                                        // Grow the short row, zero the new tail.
                                        res_start_reg       <= m_len;
                                        zc_reg              <= m_len;
                                        slot_reg            <= m_slot;
                                        row_len_reg[m_slot] <= len_sat;
                                        state_reg           <= S_ZERO;
                                    end
                                    else
                                    begin
                                        res_hit_reg <= 1'b1;
                                    end
                                end
                                else
                                begin
                                    state_reg <= S_EVCHK;
                                end
                            end
                            krc_pkg::CMD_WRITE, krc_pkg::CMD_READ:
                            begin
                                res_found_reg <= pos_ok;
                                res_rd_reg    <= pos_ok && (req.cmd == krc_pkg::CMD_READ);
                            end
                            default:
                            begin
                                if (req.key != req.key2)
                                begin
                                    // Rename both rows, then walk every row.
                                    if (m_ok)
                                    begin
                                        row_key_reg[m_slot] <= req.key2;
                                    end
                                    if (m2_ok)
                                    begin
                                        row_key_reg[m2_slot] <= req.key;
                                    end
                                    lo_reg    <= (req.key < req.key2) ? req.key : req.key2;
                                    hi_reg    <= (req.key < req.key2) ? req.key2 : req.key;
                                    idx_reg   <= '0;
                                    state_reg <= S_SWROW;
                                end
                            end
                        endcase
                    end
                end
                S_ZERO:
                begin
                    if (zc_reg < len_reg)
                    begin
                        zc_reg <= zc_reg + LEN_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_EVCHK:
                begin
                    if (32'(count_reg) >= limit32)
                    begin
                        idx_reg     <= '0;
                        best_ok_reg <= 1'b0;
                        state_reg   <= S_EVSCAN;
                    end
                    else
                    begin
                        // Create the row in the lowest free slot.
                        row_valid_reg[free_slot] <= 1'b1;
                        row_key_reg[free_slot]   <= key_reg;
                        row_len_reg[free_slot]   <= len_reg;
                        count_reg                <= count_reg + CNT_W'(1);
                        slot_reg                 <= free_slot;
                        zc_reg                   <= '0;
                        state_reg                <= S_ZERO;
                    end
                end
                S_EVSCAN:
                begin
                    if (take_cur)
                    begin
                        best_slot_reg <= idx_reg;
                        best_key_reg  <= row_key_reg[idx_reg];
                        best_ok_reg   <= 1'b1;
                    end
                    if (idx_reg == LAST_SLOT)
                    begin
                        // Drop the row with the smallest key, recheck the limit.
                        if (final_ok)
                        begin
                            row_valid_reg[final_slot] <= 1'b0;
                            count_reg                 <= count_reg - CNT_W'(1);
                        end
                        state_reg <= S_EVCHK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                S_SWROW:
                begin
                    if (cur_valid && cur_len > LEN_W'(lo_reg) && cur_len > LEN_W'(hi_reg))
                    begin
                        state_reg <= S_SWRDH;
                    end
                    else
                    begin
                        if (cur_valid && cur_len > LEN_W'(lo_reg))
                        begin
                            // Row covers the low column only: drop it.
                            row_valid_reg[idx_reg] <= 1'b0;
                            count_reg              <= count_reg - CNT_W'(1);
                        end
                        if (idx_reg == LAST_SLOT)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + SLOT_W'(1);
                        end
                    end
                end
                S_SWRDH:
                begin
                    tmp_reg   <= ram_rdata;
                    state_reg <= S_SWWLO;
                end
                S_SWWLO:
                begin
                    state_reg <= S_SWWHI;
                end
                S_SWWHI:
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + SLOT_W'(1);
                        state_reg <= S_SWROW;
                    end
                end
                S_DONE:
                begin
                    // Hold until the output register is free.
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_hit_reg   <= res_hit_reg;
                        out_start_reg <= res_start_reg;
                        out_found_reg <= res_found_reg;
                        out_value_reg <= res_rd_reg ? ram_rdata : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(valid_vec)) == 32'(count_reg))
        else $error("row count out of step with valid rows");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> rsp.start_res == '0 && rsp.read_value == '0)
        else $error("hit result carries fill length or data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CACHE_ROWS))
        else $error("row count above cache size");

endmodule

// ----- tb/krc_tb_pkg.sv -----
// Testbench-side row cache predictor types.
`timescale 1ns / 1ps
package krc_tb_pkg;
    import krc_pkg::*;

    typedef struct packed {
        logic                  hit;
        logic [LEN_W-1:0]      start_res;
        logic                  found;
        logic [DATA_W-1:0]     read_value;
    } krc_result_t;
endpackage

// ----- tb/krc_checker.sv -----
// Checker: watches the cache channels, predicts each response and compares it.
`timescale 1ns / 1ps
module krc_checker (
    input  logic clk,
    input  logic rst_n,
    krc_req_if   req,
    krc_rsp_if   rsp,
    krc_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);
    import krc_pkg::*;
    import krc_tb_pkg::*;

    localparam int NROWS = CACHE_ROWS_DEF;
    localparam int RLEN  = ROW_LEN_DEF;

    logic              slot_used [NROWS];
    logic [KEY_W-1:0]  slot_key  [NROWS];
    int                slot_len  [NROWS];
    logic [DATA_W-1:0] elem      [NROWS][RLEN];
    int                row_limit;
    krc_result_t       expected_rsp [$];

    function automatic int find_row(logic [KEY_W-1:0] k);
        for (int s = 0; s < NROWS; s++)
            if (slot_used[s] && slot_key[s] == k)
                return s;
        return -1;
    endfunction

    function automatic int rows_held();
        int n;
        n = 0;
        for (int s = 0; s < NROWS; s++)
            if (slot_used[s])
                n++;
        return n;
    endfunction

    // Advance the cache image by one request and return the expected response.
    function automatic krc_result_t apply_request(logic [1:0] c, logic [KEY_W-1:0] k,
            logic [KEY_W-1:0] k2, logic [POS_W-1:0] p, logic [LEN_W-1:0] l,
            logic [DATA_W-1:0] v);
        krc_result_t r;
        int s, si, sj, lim, best, ln, lo, hi;
        logic [DATA_W-1:0] t;
        r = '0;
        ln = (l > RLEN) ? RLEN : int'(l);
        case (cmd_t'(c))
            CMD_LOOKUP:
            begin
                s = find_row(k);
                if (s >= 0)
                begin
                    r.found = 1'b1;
                    if (slot_len[s] < ln)
                    begin
                        r.start_res = LEN_W'(slot_len[s]);
                        for (int e = slot_len[s]; e < ln; e++)
                            elem[s][e] = '0;
                        slot_len[s] = ln;
                    end
                    else
                        r.hit = 1'b1;
                end
                else
                begin
                    lim = (row_limit < 1) ? 1 : (row_limit > NROWS ? NROWS : row_limit);
                    while (rows_held() >= lim)
                    begin
                        best = -1;
                        for (int q = 0; q < NROWS; q++)
                            if (slot_used[q] && (best < 0 || slot_key[q] < slot_key[best]))
                                best = q;
                        slot_used[best] = 1'b0;
                    end
                    for (s = 0; s < NROWS; s++)
                        if (!slot_used[s])
                            break;
                    if (s < NROWS)
                    begin
                        slot_used[s] = 1'b1;
                        slot_key[s]  = k;
                        slot_len[s]  = ln;
                        for (int e = 0; e < ln; e++)
                            elem[s][e] = '0;
                    end
                end
            end
            CMD_WRITE, CMD_READ:
            begin
                s = find_row(k);
                if (s >= 0 && int'(p) < slot_len[s])
                begin
                    r.found = 1'b1;
                    if (cmd_t'(c) == CMD_WRITE)
                        elem[s][p] = v;
                    else
                        r.read_value = elem[s][p];
                end
            end
            default:
            begin
                if (k != k2)
                begin
                    si = find_row(k);
                    sj = find_row(k2);
                    lo = (k < k2) ? int'(k) : int'(k2);
                    hi = (k < k2) ? int'(k2) : int'(k);
                    if (si >= 0)
                        slot_key[si] = k2;
                    if (sj >= 0)
                        slot_key[sj] = k;
                    for (int q = 0; q < NROWS; q++)
                    begin
                        if (!slot_used[q] || slot_len[q] <= lo)
                            continue;
                        if (slot_len[q] > hi)
                        begin
                            t = elem[q][lo];
                            elem[q][lo] = elem[q][hi];
                            elem[q][hi] = t;
                        end
                        else
                            slot_used[q] = 1'b0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    assign pending = expected_rsp.size();

    always @(posedge clk or negedge rst_n)
    begin
        krc_result_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NROWS; s++)
            begin
                slot_used[s] = 1'b0;
                slot_key[s]  = '0;
                slot_len[s]  = 0;
            end
            row_limit = ROWS_IN_USE_RST;
            expected_rsp.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                row_limit = int'(cfg.rows_in_use);
            if (req.valid && req.ready)
                expected_rsp.push_back(apply_request(req.cmd, req.key, req.key2,
                                                     req.pos, req.length, req.value));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: response with none expected: hit=%b start=%0d found=%b val=%h",
                             $time, rsp.hit, rsp.start_res, rsp.found, rsp.read_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        $display("%0t: hit expected %b actual %b", $time, want.hit, rsp.hit);
                        fail_count++;
                    end
                    if (rsp.start_res !== want.start_res)
                    begin
                        $display("%0t: start_res expected %0d actual %0d",
                                 $time, want.start_res, rsp.start_res);
                        fail_count++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t: found expected %b actual %b", $time, want.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, rsp.read_value);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/tb_kernel_row_cache.sv -----
// Top of the kernel row cache testbench: stimulus, response stalls and verdict.
`timescale 1ns / 1ps
module tb_kernel_row_cache;
    import krc_pkg::*;

    // Cycles without any handshake before the run is declared hung. The worst
    // request is a lookup with eviction scans plus 1024 zeroed elements.
    localparam int HANG_LIMIT = 40000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   calm;            // true during the stretch with no idling at all
    bit   stim_done;
    logic [KEY_W-1:0] key_pool [8];

    krc_req_if req ();
    krc_rsp_if rsp ();
    krc_cfg_if cfg ();

    kernel_row_cache DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    krc_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Stall the response side about a quarter of the time, except when calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= calm || ($urandom_range(99) >= 24);
    end

    // Watchdog: count cycles in which nothing is handed over on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
                || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("FAIL kernel_row_cache");
            $finish;
        end
    end

    // Drive one request, with a random gap before it, and hold it until taken.
    task automatic send_request(cmd_t c, logic [KEY_W-1:0] k, logic [KEY_W-1:0] k2,
                                logic [POS_W-1:0] p, logic [LEN_W-1:0] l,
                                logic [DATA_W-1:0] v);
        while (!calm && $urandom_range(99) < 24)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.cmd    <= c;
        req.key    <= k;
        req.key2   <= k2;
        req.pos    <= p;
        req.length <= l;
        req.value  <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Drain all responses, let the block settle, then write the row limit.
    task automatic set_row_limit(logic [CFG_W-1:0] n);
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        cfg.valid       <= 1'b1;
        cfg.rows_in_use <= n;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        return ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : KEY_W'($urandom());
    endfunction

    // Mostly short rows; now and then a long or over-long request.
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return LEN_W'($urandom_range(40));
        if (r < 95)
            return LEN_W'($urandom_range(1023, 1000));
        return LEN_W'($urandom_range(2047, 1024));
    endfunction

    // One random request, weighted toward hitting rows that exist.
    task automatic random_request();
        int       r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(99);
        k = pick_key();
        if (r < 30)
            send_request(CMD_LOOKUP, k, KEY_W'($urandom()), POS_W'($urandom()),
                         pick_len(), rand_word());
        else if (r < 60)
            send_request(CMD_WRITE, k, KEY_W'($urandom()),
                         ($urandom_range(9) == 0) ? POS_W'($urandom()) : POS_W'($urandom_range(45)),
                         LEN_W'($urandom()), rand_word());
        else if (r < 90)
            send_request(CMD_READ, k, KEY_W'($urandom()),
                         ($urandom_range(9) == 0) ? POS_W'($urandom()) : POS_W'($urandom_range(45)),
                         LEN_W'($urandom()), rand_word());
        else
            send_request(CMD_SWAP, k, ($urandom_range(3) == 0) ? KEY_W'($urandom_range(40)) : pick_key(),
                         POS_W'($urandom()), LEN_W'($urandom()), rand_word());
    endtask

    initial
    begin
        logic [CFG_W-1:0] limits [6];
        limits = '{5'd1, 5'd3, 5'd0, 5'd31, 5'd8, 5'd16};
        rst_n           = 1'b0;
        calm            = 1'b0;
        stim_done       = 1'b0;
        idle_cycles     = 0;
        req.valid       = 1'b0;
        req.cmd         = CMD_LOOKUP;
        req.key         = '0;
        req.key2        = '0;
        req.pos         = '0;
        req.length      = '0;
        req.value       = '0;
        cfg.valid       = 1'b0;
        cfg.rows_in_use = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: create, grow, over-long request, accesses in and out of range.
        send_request(CMD_READ, 10'd5, '0, 10'd0, '0, '0);           // absent row
        send_request(CMD_LOOKUP, 10'd5, '0, '0, 11'd4, '0);         // miss creates row
        send_request(CMD_LOOKUP, 10'd5, '0, '0, 11'd4, '0);         // full hit
        send_request(CMD_LOOKUP, 10'd5, '0, '0, 11'd9, '0);         // short row grows
        send_request(CMD_WRITE, 10'd5, '0, 10'd8, '0, '1);
        send_request(CMD_WRITE, 10'd5, '0, 10'd9, '0, '1);          // beyond length
        send_request(CMD_READ, 10'd5, '0, 10'd8, '0, '0);
        send_request(CMD_READ, 10'd5, '0, 10'd7, '0, '0);           // zeroed element
        send_request(CMD_LOOKUP, 10'd1023, 10'h3FF, 10'h3FF, 11'd2047, '1); // saturates
        send_request(CMD_WRITE, 10'd1023, '0, 10'd1023, '0, 64'hA5A5_0000_FFFF_1234);
        send_request(CMD_READ, 10'd1023, '0, 10'd1023, '0, '0);
        send_request(CMD_LOOKUP, 10'd0, '0, '0, 11'd0, '0);         // empty row
        send_request(CMD_READ, 10'd0, '0, 10'd0, '0, '0);
        send_request(CMD_WRITE, 10'd5, '0, 10'd2, '0, 64'h1111);
        send_request(CMD_SWAP, 10'd2, 10'd8, '0, '0, '0);           // swaps columns
        send_request(CMD_SWAP, 10'd3, 10'd3, '0, '0, '0);           // equal keys
        send_request(CMD_SWAP, 10'd1023, 10'd77, '0, '0, '0);       // renames single row
        send_request(CMD_READ, 10'd77, '0, 10'd1023, '0, '0);
        send_request(CMD_READ, 10'd1023, '0, 10'd0, '0, '0);

        // Random phases, one per row limit; the calm stretch is in the middle.
        foreach (limits[ph])
        begin
            set_row_limit(limits[ph]);
            for (int i = 0; i < 8; i++)
                key_pool[i] = KEY_W'($urandom());
            calm = (ph == 3);
            for (int n = 0; n < 185; n++)
                random_request();
        end
        calm = 1'b0;
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Verdict: wait for every response, then a short settling time.
    initial
    begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS kernel_row_cache");
        else
            $display("FAIL kernel_row_cache");
        $finish;
    end
endmodule
